[hdl/haar_wavelet_lifting_1d_macros.svh]
// ----------------------------------------------------------------------------
// Haar lifting assertion macros
// Shared assertion helpers for the Haar lifting block.
// ----------------------------------------------------------------------------
`ifndef HAAR_WAVELET_LIFTING_1D_MACROS_SVH
`define HAAR_WAVELET_LIFTING_1D_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HWL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define HWL_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define HWL_ASSERT(label, clk, rst_n, prop)
`define HWL_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[hdl/hwl_pkg.sv]
// ----------------------------------------------------------------------------
// Haar lifting package
// Types and constants shared by the Haar lifting modules.
// ----------------------------------------------------------------------------
package hwl_pkg;
  localparam int unsigned MaxBlockDefault = 4096;
  localparam int unsigned InW   = 18;
  localparam int unsigned OutW  = 19;
  localparam int unsigned SizeW = 13;
  localparam int unsigned SumW  = 40;
  localparam int unsigned QW    = 56;

  localparam logic [0:0] RegDirection = 1'b0;
  localparam logic [0:0] RegBlockSize = 1'b1;

  // One classified item handed from the front part to the back part.
  typedef struct packed {
    logic                   lone;
    logic                   last;
    logic signed [OutW-1:0] first;
    logic signed [OutW-1:0] second;
    logic signed [SumW-1:0] dividend;
    logic signed [SumW-1:0] out_sum;
  } hwl_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIX,
    BK_OUT
  } hwl_back_state_e;

  function automatic logic signed [OutW-1:0] sat19(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(262143);
    lo = -SumW'(262144);
    if (v > hi) return OutW'(262143);
    if (v < lo) return -OutW'(262144);
    return v[OutW-1:0];
  endfunction
endpackage

[hdl/hwl_front.sv]
// ----------------------------------------------------------------------------
// Haar lifting front part
// Accepts items, computes pair results, keeps running sums, flags lone items.
// ----------------------------------------------------------------------------
module hwl_front import hwl_pkg::*; #(
  parameter int unsigned MaxBlock = MaxBlockDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clear_i,
  input  logic                   direction_i,
  input  logic [SizeW-1:0]       size_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [InW-1:0]  first_i,
  input  logic signed [InW-1:0]  second_i,
  output logic                   item_valid_o,
  input  logic                   item_ready_i,
  output hwl_item_t              item_o
);
  logic signed [SumW-1:0] in_sum_q, in_sum_d, out_sum_q, out_sum_d;
  logic [SizeW-1:0] pos_q, pos_d;
  logic [SizeW-1:0] n_g;
  logic odd, lone, pair_last, acc;
  logic signed [SumW-1:0] x, y, r0, r1, in_new;

  assign n_g  = size_i >> 1;
  assign odd  = size_i[0];
  assign lone = odd && (pos_q >= n_g);
  assign pair_last = !odd && ((pos_q + SizeW'(1)) >= n_g);
  assign x = SumW'(first_i);
  assign y = SumW'(second_i);
  assign r0 = direction_i ? (x - y) : (x + y);
  assign r1 = direction_i ? (x + y) : (y - x);
  assign in_new = in_sum_q + (direction_i ? x : (x + y));
  assign ready_o = item_ready_i;
  assign item_valid_o = valid_i;
  assign acc = valid_i && item_ready_i;

  always_comb begin
    item_o.lone = lone;
    item_o.last = lone || pair_last;
    item_o.first = sat19(r0);
    item_o.second = sat19(r1);
    item_o.dividend = in_sum_q + x;
    item_o.out_sum = out_sum_q;
  end

  always_comb begin
    in_sum_d = in_sum_q;
    out_sum_d = out_sum_q;
    pos_d = pos_q;
    if (clear_i) begin
      in_sum_d = '0; out_sum_d = '0; pos_d = '0;
    end else if (acc) begin
      if (lone || pair_last) begin
        in_sum_d = '0; out_sum_d = '0; pos_d = '0;
      end else begin
        in_sum_d = in_new;
        out_sum_d = out_sum_q + (direction_i ? (r0 + r1) : r0);
        pos_d = pos_q + SizeW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sum_q <= '0; out_sum_q <= '0; pos_q <= '0;
    end else begin
      in_sum_q <= in_sum_d; out_sum_q <= out_sum_d; pos_q <= pos_d;
    end
  end
endmodule

[hdl/hwl_back.sv]
// ----------------------------------------------------------------------------
// Haar lifting back part
// Holds one queued item, runs the lone-item division, presents results.
// ----------------------------------------------------------------------------
module hwl_back import hwl_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   direction_i,
  input  logic [SizeW-1:0]       size_i,
  input  logic                   item_valid_i,
  output logic                   item_ready_o,
  input  hwl_item_t              item_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic signed [OutW-1:0] out_first_o,
  output logic signed [OutW-1:0] out_second_o,
  output logic                   second_valid_o,
  output logic                   last_o
);
  `include "haar_wavelet_lifting_1d_macros.svh"

  hwl_back_state_e st_q, st_d;
  logic [QW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [SizeW-1:0] div_q, div_d;
  logic [5:0] cnt_q, cnt_d;
  logic neg_q, neg_d;
  logic signed [SumW-1:0] osum_q, osum_d;
  logic signed [OutW-1:0] f_q, f_d, s_q, s_d;
  logic sv_q, sv_d, l_q, l_d;
  logic [SizeW-1:0] n_l;
  logic signed [QW-1:0] prod;
  logic [QW-1:0] mag, rem_sh;
  logic signed [QW-1:0] qs;
  logic take, out_free;

  assign n_l = size_i - (size_i >> 1);
  assign prod = direction_i ? (QW'(item_i.dividend) * $signed({1'b0, size_i}))
                            : (QW'(item_i.dividend) * $signed({1'b0, n_l}) * QW'(2));
  assign mag = prod[QW-1] ? QW'(-prod) : QW'(prod);
  assign out_free = (st_q == BK_IDLE) || (st_q == BK_OUT && ready_i);
  assign item_ready_o = out_free;
  assign take = item_valid_i && out_free;
  assign rem_sh = {rem_q[QW-2:0], quo_q[QW-1]};
  assign qs = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_comb begin
    st_d = st_q; rem_d = rem_q; quo_d = quo_q; div_d = div_q; cnt_d = cnt_q;
    neg_d = neg_q; osum_d = osum_q;
    case (st_q)
      BK_IDLE, BK_OUT: begin
        if (take) begin
          if (item_i.lone) begin
            st_d = BK_DIV; rem_d = '0; quo_d = mag; neg_d = prod[QW-1];
            div_d = direction_i ? n_l : size_i; cnt_d = 6'(QW);
            osum_d = item_i.out_sum;
          end else begin
            st_d = BK_OUT;
          end
        end else if (st_q == BK_OUT && ready_i) begin
          st_d = BK_IDLE;
        end
      end
      BK_DIV: begin
        if (rem_sh >= QW'(div_q)) begin
          rem_d = rem_sh - QW'(div_q); quo_d = {quo_q[QW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh; quo_d = {quo_q[QW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) st_d = BK_FIX;
      end
      BK_FIX: st_d = BK_OUT;
      default: st_d = BK_IDLE;
    endcase
  end

  always_comb begin
    f_d = f_q; s_d = s_q; sv_d = sv_q; l_d = l_q;
    if (take && !item_i.lone) begin
      f_d = item_i.first; s_d = item_i.second; sv_d = 1'b1; l_d = item_i.last;
    end else if (st_q == BK_FIX) begin
      f_d = sat19(SumW'(qs) - osum_q); s_d = '0; sv_d = 1'b0; l_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE; cnt_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; div_q <= div_d; neg_q <= neg_d; osum_q <= osum_d;
    f_q <= f_d; s_q <= s_d; sv_q <= sv_d; l_q <= l_d;
  end

  assign valid_o = (st_q == BK_OUT);
  assign out_first_o = f_q;
  assign out_second_o = s_q;
  assign second_valid_o = sv_q;
  assign last_o = l_q;

  `HWL_ASSERT(a_div_len, clk_i, rst_ni, (st_q == BK_DIV && cnt_q == 6'd1) |=> st_q == BK_FIX)
  `HWL_ASSERT(a_fix_out, clk_i, rst_ni, st_q == BK_FIX |=> (st_q == BK_OUT && !second_valid_o && last_o))
  `HWL_ASSERT_NEVER(a_no_take_busy, clk_i, rst_ni, item_ready_o && (st_q == BK_DIV || st_q == BK_FIX))
endmodule

[hdl/haar_wavelet_lifting_1d.sv]
// ----------------------------------------------------------------------------
// Haar wavelet lifting, one level, one dimension
// Forward or inverse Haar lifting over a block with average-preserving tail.
// ----------------------------------------------------------------------------
// A pair item is accepted while the previous result is still waiting to be
// taken, as long as the output register drains; pairs flow at one per cycle
// while the output is not stalled, and a result shows in the cycle after its
// transfer. The lone final item of an odd block runs through a restoring
// divider that resolves one quotient bit per cycle, then a fix step, before
// its result appears, and no item is taken meanwhile. Writing either register
// restarts the block; block size 0 acts as 1 and sizes above MaxBlock clip.
module haar_wavelet_lifting_1d import hwl_pkg::*; #(
  parameter int unsigned MaxBlock = MaxBlockDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [SizeW-1:0]       cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [InW-1:0]  first_value_i,
  input  logic signed [InW-1:0]  second_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] out_first_o,
  output logic signed [OutW-1:0] out_second_o,
  output logic                   second_valid_o,
  output logic                   last_o
);
  logic dir_q, dir_d;
  logic [SizeW-1:0] bsz_q, bsz_d, eff_size;
  logic cfg_wr, iv;
  hwl_item_t item;
  logic item_ready;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr = cfg_valid_i;

  always_comb begin
    dir_d = dir_q; bsz_d = bsz_q;
    if (cfg_wr) begin
      case (cfg_index_i)
        RegDirection: dir_d = cfg_data_i[0];
        RegBlockSize: bsz_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective size: zero acts as one, large sizes clip to MaxBlock.
  always_comb begin
    if (bsz_q == '0) eff_size = SizeW'(1);
    else if ({19'd0, bsz_q} > 32'(MaxBlock)) eff_size = SizeW'(MaxBlock);
    else eff_size = bsz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0; bsz_q <= SizeW'(4096);
    end else begin
      dir_q <= dir_d; bsz_q <= bsz_d;
    end
  end

  hwl_front #(.MaxBlock(MaxBlock)) u_front (
    .clk_i, .rst_ni, .clear_i(cfg_wr), .direction_i(dir_q), .size_i(eff_size),
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .first_i(first_value_i), .second_i(second_value_i),
    .item_valid_o(iv), .item_ready_i(item_ready), .item_o(item)
  );

  hwl_back u_back (
    .clk_i, .rst_ni, .direction_i(dir_q), .size_i(eff_size),
    .item_valid_i(iv), .item_ready_o(item_ready), .item_i(item),
    .valid_o(out_valid_o), .ready_i(out_ready_i),
    .out_first_o, .out_second_o, .second_valid_o, .last_o
  );
endmodule
